// ===== design/lpfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lpfd_pkg
// Shared types and constants for the length-prefixed frame deframer.
// ----------------------------------------------------------------------------
package lpfd_pkg;

	localparam int unsigned BYTE_W = 8;
	localparam int unsigned LEN_W  = 32;

	localparam logic [LEN_W-1:0] MAX_LEN_RESET = 32'd1048576;

	typedef enum logic [1:0] {
		KIND_TYPE    = 2'd0,
		KIND_PAYLOAD = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] data;
	} stage_t;

endpackage

// ===== design/lpfd_in_reg.sv =====
// ----------------------------------------------------------------------------
// lpfd_in_reg
// Input register stage: captures one stream byte per transfer.
// ----------------------------------------------------------------------------
module lpfd_in_reg (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [lpfd_pkg::BYTE_W-1:0] rx_byte,
	output lpfd_pkg::stage_t           stage_s1,
	input  logic                       take_s1
);
	import lpfd_pkg::*;

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	assign in_ready = !valid_s1 || take_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= rx_byte;
		end
	end

	assign stage_s1.valid = valid_s1;
	assign stage_s1.data  = byte_s1;

endmodule

// ===== design/lpfd_parser.sv =====
// ----------------------------------------------------------------------------
// lpfd_parser
// Frame state, length check and result register.
// ----------------------------------------------------------------------------
module lpfd_parser (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [lpfd_pkg::LEN_W-1:0]  cfg_wr_data,
	input  lpfd_pkg::stage_t            stage_s1,
	output logic                        take_s1,
	output logic                        out_valid,
	input  logic                        out_ready,
	output lpfd_pkg::kind_t             kind_s2,
	output logic [lpfd_pkg::BYTE_W-1:0] data_s2,
	output logic                        last_s2
);
	import lpfd_pkg::*;

	typedef enum logic [1:0] {
		PH_HEADER  = 2'd0,
		PH_TYPE    = 2'd1,
		PH_PAYLOAD = 2'd2,
		PH_ERROR   = 2'd3
	} phase_t;

	phase_t             phase_q, phase_d;
	logic [1:0]         hdr_cnt_q, hdr_cnt_d;
	logic [LEN_W-1:0]   len_q, len_d;
	logic [LEN_W-1:0]   rem_q, rem_d;
	logic [LEN_W-1:0]   max_q;
	logic [LEN_W-1:0]   acc;
	logic               res_vld;
	kind_t              res_kind;
	logic               res_last;
	logic               out_valid_q;

	assign take_s1   = stage_s1.valid && (!out_valid_q || out_ready);
	assign out_valid = out_valid_q;

	always_comb begin
		phase_d   = phase_q;
		hdr_cnt_d = hdr_cnt_q;
		len_d     = len_q;
		rem_d     = rem_q;
		res_vld   = 1'b0;
		res_kind  = KIND_TYPE;
		res_last  = 1'b0;
		acc       = len_q;
		acc[{hdr_cnt_q, 3'b000} +: BYTE_W] = stage_s1.data;
		case (phase_q)
			PH_HEADER: begin
				if (hdr_cnt_q != 2'd3) begin
					hdr_cnt_d = hdr_cnt_q + 2'd1;
					len_d     = acc;
				end else begin
					hdr_cnt_d = 2'd0;
					len_d     = '0;
					if (acc == '0 || acc > max_q) begin
						phase_d  = PH_ERROR;
						res_vld  = 1'b1;
						res_kind = KIND_ERROR;
					end else begin
						rem_d   = acc;
						phase_d = PH_TYPE;
					end
				end
			end
			PH_TYPE, PH_PAYLOAD: begin
				res_vld  = 1'b1;
				res_kind = (phase_q == PH_TYPE) ? KIND_TYPE : KIND_PAYLOAD;
				res_last = (rem_q <= 32'd1);
				if (res_last) begin
					rem_d   = '0;
					phase_d = PH_HEADER;
				end else begin
					rem_d   = rem_q - 32'd1;
					phase_d = PH_PAYLOAD;
				end
			end
			default: begin
				phase_d = PH_ERROR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			hdr_cnt_q   <= 2'd0;
			len_q       <= '0;
			rem_q       <= '0;
			max_q       <= MAX_LEN_RESET;
			out_valid_q <= 1'b0;
			kind_s2     <= KIND_TYPE;
			data_s2     <= '0;
			last_s2     <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				max_q <= cfg_wr_data;
			end
			if (take_s1) begin
				phase_q   <= phase_d;
				hdr_cnt_q <= hdr_cnt_d;
				len_q     <= len_d;
				rem_q     <= rem_d;
			end
			if (take_s1 && res_vld) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (take_s1 && res_vld) begin
				kind_s2 <= res_kind;
				data_s2 <= (res_kind == KIND_ERROR) ? '0 : stage_s1.data;
				last_s2 <= res_last;
			end
		end
	end

endmodule

// ===== design/length_prefixed_frame_deframer.sv =====
// ----------------------------------------------------------------------------
// length_prefixed_frame_deframer
// Splits a byte stream of 32-bit little-endian length-prefixed frames into
// type, payload and error results.
// Results: an input byte passes the input register, then the result register.
// Throughput: one byte per cycle; a stalled result register holds the input.
// Reset: asynchronous; clears the frame state and sets the maximum length to
// 1048576. After a length error all bytes are dropped until reset.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_wr_en,
	input  logic [lpfd_pkg::LEN_W-1:0]  cfg_wr_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [lpfd_pkg::BYTE_W-1:0] rx_byte,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  item_kind,
	output logic [lpfd_pkg::BYTE_W-1:0] item_data,
	output logic                        frame_last
);
	import lpfd_pkg::*;

	stage_t stage_s1;
	logic   take_s1;
	kind_t  kind_s2;

	lpfd_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.stage_s1 (stage_s1),
		.take_s1  (take_s1)
	);

	lpfd_parser u_parser (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.stage_s1    (stage_s1),
		.take_s1     (take_s1),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.kind_s2     (kind_s2),
		.data_s2     (item_data),
		.last_s2     (frame_last)
	);

	assign item_kind = kind_s2;

endmodule
